[design/dcau_pkg.sv]
`default_nettype none
package dcau_pkg;

	localparam int unsigned CELL_BITS = 16;
	localparam int unsigned DBL_BITS  = 2 * CELL_BITS;
	localparam int unsigned DIV_STEPS = DBL_BITS;

	localparam logic [2:0] OP_UMUL    = 3'd0;
	localparam logic [2:0] OP_UDIVMOD = 3'd1;
	localparam logic [2:0] OP_DADD    = 3'd2;
	localparam logic [2:0] OP_DSUB    = 3'd3;
	localparam logic [2:0] OP_DNEG    = 3'd4;

	typedef struct packed {
		logic [2:0]           op;
		logic [CELL_BITS-1:0] x_lo;
		logic [CELL_BITS-1:0] x_hi;
		logic [CELL_BITS-1:0] y_lo;
		logic [CELL_BITS-1:0] y_hi;
	} req_t;

	typedef struct packed {
		logic [CELL_BITS-1:0] res_lo;
		logic [CELL_BITS-1:0] res_hi;
		logic                 div_zero;
	} rsp_t;

	// Work carried down the divider chain. For every beat other than a live
	// division dq already holds the finished double cell and passes through.
	typedef struct packed {
		logic                 is_div;
		logic                 div_zero;
		logic [CELL_BITS-1:0] rem;
		logic [DBL_BITS-1:0]  dq;
		logic [CELL_BITS-1:0] dvs;
	} work_t;

endpackage
`default_nettype wire

[design/double_cell_arithmetic_unit_core.sv]
// Path: the front register loads on the accepting edge, then one cell per
// quotient bit over 32 cells, then the output register raises rsp_valid.
// Throughput: one beat per cycle unless a full skid entry stalls the chain;
// every opcode travels the same cell chain.
// Reset: arst_n clears all valid bits and the skid entry at once; payload
// registers are left uncleared.
`default_nettype none
module double_cell_arithmetic_unit_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_ready,
	input  dcau_pkg::req_t      req,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output dcau_pkg::rsp_t      rsp
);
	import dcau_pkg::*;

	// stage 0 is the front register, stages 1..DIV_STEPS the divider cells
	logic  stage_valid [DIV_STEPS+1];
	work_t stage_work  [DIV_STEPS+1];
	logic  room;
	logic  en;

	// Advance the whole chain unless the last cell is full and the output
	// buffer has no room; the buffer's room is a register, so ready never
	// depends combinationally on rsp_ready.
	assign en        = !stage_valid[DIV_STEPS] || room;
	assign req_ready = en;

	// Decode, multiply, add/subtract and negate; load the dividend for division.
	dcau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.beat_valid (req_valid),
		.beat       (req),
		.valid_s1   (stage_valid[0]),
		.work_s1    (stage_work[0])
	);

	// One restoring-division cell per dividend bit; non-division beats
	// pass straight through and keep their place in order.
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		dcau_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_d (stage_valid[i]),
			.work_d  (stage_work[i]),
			.valid_q (stage_valid[i+1]),
			.work_q  (stage_work[i+1])
		);
	end

	// Format the result and hold it in an output register with a skid entry.
	dcau_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (stage_valid[DIV_STEPS] && room),
		.work      (stage_work[DIV_STEPS]),
		.room      (room),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

[design/dcau_front.sv]
`default_nettype none
module dcau_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 beat_valid,
	input  dcau_pkg::req_t      beat,
	output logic                valid_s1,
	output dcau_pkg::work_t     work_s1
);
	import dcau_pkg::*;

	logic [DBL_BITS-1:0] x_dbl;
	logic [DBL_BITS-1:0] y_dbl;
	logic [DBL_BITS-1:0] prod;
	logic                dvs_zero;
	work_t               work_d;

	assign x_dbl    = {beat.x_hi, beat.x_lo};
	assign y_dbl    = {beat.y_hi, beat.y_lo};
	assign prod     = DBL_BITS'(beat.x_lo) * DBL_BITS'(beat.y_lo);
	assign dvs_zero = (beat.y_lo == '0);

	always_comb begin
		work_d          = '0;
		work_d.dvs      = beat.y_lo;
		unique case (beat.op)
			OP_UMUL: begin
				work_d.dq = prod;
			end
			OP_UDIVMOD: begin
				// a zero divisor answers all ones and passes through the chain undivided
				work_d.is_div   = !dvs_zero;
				work_d.div_zero = dvs_zero;
				work_d.dq       = dvs_zero ? '1 : x_dbl;
			end
			OP_DADD: begin
				work_d.dq = x_dbl + y_dbl;
			end
			OP_DSUB: begin
				work_d.dq = x_dbl - y_dbl;
			end
			OP_DNEG: begin
				work_d.dq = '0 - x_dbl;
			end
			default: begin
				work_d.dq = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= work_d;
		end
	end

endmodule
`default_nettype wire

[design/dcau_div_cell.sv]
`default_nettype none
module dcau_div_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 valid_d,
	input  dcau_pkg::work_t     work_d,
	output logic                valid_q,
	output dcau_pkg::work_t     work_q
);
	import dcau_pkg::*;

	logic [CELL_BITS:0] trial;
	logic [CELL_BITS:0] diff;
	logic               take;
	work_t              work_n;

	// one restoring step: shift the next dividend bit into the remainder
	assign trial = {work_d.rem, work_d.dq[DBL_BITS-1]};
	assign diff  = trial - {1'b0, work_d.dvs};
	assign take  = (trial >= {1'b0, work_d.dvs});

	always_comb begin
		work_n = work_d;
		if (work_d.is_div) begin
			work_n.rem = take ? diff[CELL_BITS-1:0] : trial[CELL_BITS-1:0];
			work_n.dq  = {work_d.dq[DBL_BITS-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= work_n;
		end
	end

endmodule
`default_nettype wire

[design/dcau_out_buf.sv]
`default_nettype none
module dcau_out_buf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  dcau_pkg::work_t     work,
	output logic                room,
	output logic                rsp_valid,
	input  wire                 rsp_ready,
	output dcau_pkg::rsp_t      rsp
);
	import dcau_pkg::*;

	rsp_t rsp_d;
	rsp_t skid_q;
	logic skid_valid_q;

	always_comb begin
		rsp_d.div_zero = work.div_zero;
		rsp_d.res_lo   = work.dq[CELL_BITS-1:0];
		rsp_d.res_hi   = work.is_div ? work.rem : work.dq[DBL_BITS-1:CELL_BITS];
	end

	assign room = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!rsp_valid || rsp_ready) begin
			if (skid_valid_q) begin
				rsp_valid    <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				rsp_valid <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!rsp_valid || rsp_ready) begin
			rsp <= skid_valid_q ? skid_q : rsp_d;
		end else if (push) begin
			skid_q <= rsp_d;
		end
	end

endmodule
`default_nettype wire
